// ----- design/quaternion_to_euler_angles_assert.svh -----
// assertion macros for the quaternion to euler angles block
// expects clk and rst_n in the including scope
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// implication checked at every clock edge outside reset
`define QTE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must hold at every clock edge outside reset
`define QTE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- design/qte_pkg.sv -----
// shared types, constants and tables for the quaternion to euler angles block
// no dependencies
package qte_pkg;

    localparam int QUAT_WIDTH_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int SEQ_W   = 4;
    localparam int NUM_SEQ = 12;
    localparam logic [SEQ_W-1:0] SEQ_RESET = 4'd4;

    localparam int PROD_W = 32;
    localparam int TERM_W = 35;
    localparam int CORD_W = 36;
    localparam int ANG_W  = 28;
    localparam int OUT_W  = 16;
    localparam int SQ_W   = 62;
    localparam int SQRT_STEPS = 31;

    localparam logic signed [ANG_W-1:0] DEG180  = ANG_W'(180 * 65536);
    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sd23040;
    localparam logic signed [PROD_W-1:0] ONE_Q30 = 32'sd1073741824;

    // latencies of the front end and the square root
    localparam int PROD_LAT = 4;
    localparam int SQRT_LAT = SQRT_STEPS + 1;

    // term codes
    localparam logic signed [4:0] TM_ZERO  = 5'sd0;
    localparam logic signed [4:0] TM_SXY_P = 5'sd1;
    localparam logic signed [4:0] TM_SXY_M = 5'sd2;
    localparam logic signed [4:0] TM_SXZ_P = 5'sd3;
    localparam logic signed [4:0] TM_SXZ_M = 5'sd4;
    localparam logic signed [4:0] TM_SYZ_P = 5'sd5;
    localparam logic signed [4:0] TM_SYZ_M = 5'sd6;
    localparam logic signed [4:0] TM_DX    = 5'sd7;
    localparam logic signed [4:0] TM_DY    = 5'sd8;
    localparam logic signed [4:0] TM_DZ    = 5'sd9;

    typedef struct packed {
        logic signed [TERM_W-1:0] r11;
        logic signed [TERM_W-1:0] r12;
        logic signed [TERM_W-1:0] r31;
        logic signed [TERM_W-1:0] r32;
        logic signed [PROD_W-1:0] c;
        logic                     odd;
        logic                     bad;
        logic                     clamped;
    } qte_pay_t;

    // codes for r11, r12, r21, r31, r32, r11 in the low bits
    function automatic logic [24:0] seq_row(input logic [SEQ_W-1:0] seq);
        logic [24:0] row;
        begin
            unique case (seq)
                4'd0:  row = {TM_DZ, TM_SYZ_P, -TM_SXZ_M, TM_DX, TM_SXY_P};
                4'd1:  row = {-TM_SXZ_M, TM_SYZ_P, TM_DZ, TM_SXZ_P, TM_SYZ_M};
                4'd2:  row = {TM_DZ, -TM_SXZ_M, TM_SYZ_P, TM_DY, -TM_SXY_M};
                4'd3:  row = {TM_SYZ_P, TM_SXZ_M, TM_DZ, -TM_SYZ_M, TM_SXZ_P};
                4'd4:  row = {TM_DY, TM_SXY_P, -TM_SYZ_M, TM_DZ, TM_SXZ_P};
                4'd5:  row = {-TM_SYZ_M, TM_SXY_P, TM_DY, TM_SYZ_P, TM_SXY_M};
                4'd6:  row = {TM_DY, -TM_SYZ_M, TM_SXY_P, TM_DX, -TM_SXZ_M};
                4'd7:  row = {TM_SXY_P, TM_SYZ_M, TM_DY, -TM_SXY_M, TM_SYZ_P};
                4'd8:  row = {TM_DX, -TM_SXY_M, TM_SXZ_P, TM_DZ, -TM_SYZ_M};
                4'd9:  row = {TM_SXZ_P, TM_SXY_M, TM_DX, -TM_SXZ_M, TM_SXY_P};
                4'd10: row = {TM_DX, TM_SXZ_P, -TM_SXY_M, TM_DY, TM_SYZ_P};
                4'd11: row = {-TM_SXY_M, TM_SXZ_P, TM_DX, TM_SXY_P, TM_SXZ_M};
                default: row = {TM_ZERO, TM_ZERO, TM_ZERO, TM_ZERO, TM_ZERO};
            endcase
            return row;
        end
    endfunction

    // atan(2^-i) in degrees * 65536
    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] i);
        logic signed [ANG_W-1:0] a;
        begin
            unique case (i)
                5'd0:  a = 28'sd2949120;
                5'd1:  a = 28'sd1740967;
                5'd2:  a = 28'sd919879;
                5'd3:  a = 28'sd466945;
                5'd4:  a = 28'sd234379;
                5'd5:  a = 28'sd117304;
                5'd6:  a = 28'sd58666;
                5'd7:  a = 28'sd29335;
                5'd8:  a = 28'sd14668;
                5'd9:  a = 28'sd7334;
                5'd10: a = 28'sd3667;
                5'd11: a = 28'sd1833;
                5'd12: a = 28'sd917;
                5'd13: a = 28'sd458;
                5'd14: a = 28'sd229;
                5'd15: a = 28'sd115;
                5'd16: a = 28'sd57;
                5'd17: a = 28'sd29;
                5'd18: a = 28'sd14;
                5'd19: a = 28'sd7;
                5'd20: a = 28'sd4;
                5'd21: a = 28'sd2;
                5'd22: a = 28'sd1;
                default: a = 28'sd0;
            endcase
            return a;
        end
    endfunction

endpackage

// ----- design/qte_products.sv -----
// front end: input register, pairwise products, term selection, clamp and c squared
// depends on qte_pkg
module qte_products #(
    parameter int QUAT_WIDTH = qte_pkg::QUAT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [QUAT_WIDTH-1:0]     q_w,
    input  logic signed [QUAT_WIDTH-1:0]     q_x,
    input  logic signed [QUAT_WIDTH-1:0]     q_y,
    input  logic signed [QUAT_WIDTH-1:0]     q_z,
    input  logic [qte_pkg::SEQ_W-1:0]        seq,
    output logic                             out_valid,
    output logic [qte_pkg::SQ_W-1:0]         c_sq,
    output qte_pkg::qte_pay_t                pay
);
    import qte_pkg::*;

    localparam int FB  = 2 * (QUAT_WIDTH - 1);
    localparam int SHR = (FB >= 30) ? FB - 30 : 0;
    localparam int SHL = (FB < 30) ? 30 - FB : 0;
    localparam int MW  = 2 * QUAT_WIDTH;

    // stage a: inputs
    logic                         va_reg;
    logic signed [QUAT_WIDTH-1:0] w_reg, x_reg, y_reg, z_reg;
    logic [SEQ_W-1:0]             seqa_reg;

    // stage b: products in q.30
    logic                     vb_reg;
    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [PROD_W-1:0] wx_reg, wy_reg, wz_reg;
    logic [SEQ_W-1:0]         seqb_reg;

    // stage c: selected terms
    logic     vc_reg;
    qte_pay_t payc_reg;
    qte_pay_t payc_next;

    // stage d: c squared
    logic              vd_reg;
    logic [SQ_W-1:0]   csq_reg;
    qte_pay_t          payd_reg;

    function automatic logic signed [PROD_W-1:0] q30(input logic signed [QUAT_WIDTH-1:0] a,
                                                    input logic signed [QUAT_WIDTH-1:0] b);
        logic signed [MW-1:0] p;
        logic signed [63:0]   p64;
        begin
            p   = a * b;
            p64 = 64'(p);
            p64 = (p64 >>> SHR) <<< SHL;
            return p64[PROD_W-1:0];
        end
    endfunction

    function automatic logic signed [TERM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
        return TERM_W'(p);
    endfunction

    logic signed [TERM_W-1:0] terms [10];
    logic signed [TERM_W-1:0] r [5];
    logic [24:0]              row;

    always_comb
    begin
        logic signed [4:0] code;
        logic [3:0]        mag;
        logic signed [TERM_W-1:0] t;
        terms[0] = '0;
        terms[1] = (ext(xy_reg) + ext(wz_reg)) <<< 1;
        terms[2] = (ext(xy_reg) - ext(wz_reg)) <<< 1;
        terms[3] = (ext(xz_reg) + ext(wy_reg)) <<< 1;
        terms[4] = (ext(xz_reg) - ext(wy_reg)) <<< 1;
        terms[5] = (ext(yz_reg) + ext(wx_reg)) <<< 1;
        terms[6] = (ext(yz_reg) - ext(wx_reg)) <<< 1;
        terms[7] = ext(ww_reg) + ext(xx_reg) - ext(yy_reg) - ext(zz_reg);
        terms[8] = ext(ww_reg) - ext(xx_reg) + ext(yy_reg) - ext(zz_reg);
        terms[9] = ext(ww_reg) - ext(xx_reg) - ext(yy_reg) + ext(zz_reg);
        row = seq_row(seqb_reg);
        for (int k = 0; k < 5; k++)
        begin
            code = signed'(row[k*5 +: 5]);
            mag  = code[4] ? 4'(-code) : code[3:0];
            unique case (mag)
                4'd1:    t = terms[1];
                4'd2:    t = terms[2];
                4'd3:    t = terms[3];
                4'd4:    t = terms[4];
                4'd5:    t = terms[5];
                4'd6:    t = terms[6];
                4'd7:    t = terms[7];
                4'd8:    t = terms[8];
                4'd9:    t = terms[9];
                default: t = terms[0];
            endcase
            r[k] = code[4] ? -t : t;
        end
        payc_next.r11 = r[0];
        payc_next.r12 = r[1];
        payc_next.r31 = r[3];
        payc_next.r32 = r[4];
        payc_next.odd = seqb_reg[0];
        payc_next.bad = (seqb_reg >= SEQ_W'(NUM_SEQ));
        if (r[2] > ext(ONE_Q30))
        begin
            payc_next.c       = ONE_Q30;
            payc_next.clamped = 1'b1;
        end
        else if (r[2] < -ext(ONE_Q30))
        begin
            payc_next.c       = -ONE_Q30;
            payc_next.clamped = 1'b1;
        end
        else
        begin
            payc_next.c       = r[2][PROD_W-1:0];
            payc_next.clamped = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= q_w;
        x_reg    <= q_x;
        y_reg    <= q_y;
        z_reg    <= q_z;
        seqa_reg <= seq;

        ww_reg   <= q30(w_reg, w_reg);
        xx_reg   <= q30(x_reg, x_reg);
        yy_reg   <= q30(y_reg, y_reg);
        zz_reg   <= q30(z_reg, z_reg);
        xy_reg   <= q30(x_reg, y_reg);
        xz_reg   <= q30(x_reg, z_reg);
        yz_reg   <= q30(y_reg, z_reg);
        wx_reg   <= q30(w_reg, x_reg);
        wy_reg   <= q30(w_reg, y_reg);
        wz_reg   <= q30(w_reg, z_reg);
        seqb_reg <= seqa_reg;

        payc_reg <= payc_next;

        csq_reg  <= SQ_W'(64'(payc_reg.c) * 64'(payc_reg.c));
        payd_reg <= payc_reg;
    end

    assign out_valid = vd_reg;
    assign c_sq      = csq_reg;
    assign pay       = payd_reg;

endmodule

// ----- design/qte_isqrt.sv -----
// pipelined integer square root of 2^60 - c^2, one result bit per stage
// depends on qte_pkg
module qte_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [qte_pkg::SQ_W-1:0]    c_sq,
    input  qte_pkg::qte_pay_t           in_pay,
    output logic                        out_valid,
    output logic signed [qte_pkg::PROD_W-1:0] s,
    output qte_pkg::qte_pay_t           out_pay
);
    import qte_pkg::*;

    localparam logic [SQ_W-1:0] ONE_Q60 = SQ_W'(1) << 60;

    logic            v_reg   [SQRT_STEPS+1];
    logic [SQ_W-1:0] rem_reg [SQRT_STEPS+1];
    logic [SQ_W-1:0] res_reg [SQRT_STEPS+1];
    qte_pay_t        pay_reg [SQRT_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= ONE_Q60 - c_sq;
        res_reg[0] <= '0;
        pay_reg[0] <= in_pay;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * k);
        logic [SQ_W-1:0] sum;
        assign sum = res_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            pay_reg[k+1] <= pay_reg[k];
            if (rem_reg[k] >= sum)
            begin
                rem_reg[k+1] <= rem_reg[k] - sum;
                res_reg[k+1] <= (res_reg[k] >> 1) + BIT;
            end
            else
            begin
                rem_reg[k+1] <= rem_reg[k];
                res_reg[k+1] <= res_reg[k] >> 1;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS];
    assign s         = signed'(res_reg[SQRT_STEPS][PROD_W-1:0]);
    assign out_pay   = pay_reg[SQRT_STEPS];

endmodule

// ----- design/qte_cordic.sv -----
// pipelined vectoring cordic, atan2(y, x) in degrees * 65536
// depends on qte_pkg
module qte_cordic #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [qte_pkg::CORD_W-1:0]  y,
    input  logic signed [qte_pkg::CORD_W-1:0]  x,
    output logic                               out_valid,
    output logic signed [qte_pkg::ANG_W-1:0]   angle
);
    import qte_pkg::*;

    logic                     v_reg [CORDIC_STEPS+1];
    logic signed [CORD_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORD_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]  z_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    // half-turn pre-rotation for the left half plane
    always_ff @(posedge clk)
    begin
        if (x < 0)
        begin
            z_reg[0] <= (y >= 0) ? DEG180 : -DEG180;
            x_reg[0] <= -x;
            y_reg[0] <= -y;
        end
        else
        begin
            z_reg[0] <= '0;
            x_reg[0] <= x;
            y_reg[0] <= y;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        localparam logic signed [ANG_W-1:0] ATAN = atan_tab(5'(i));
        logic signed [CORD_W-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS];
    assign angle     = z_reg[CORDIC_STEPS];

endmodule

// ----- design/quaternion_to_euler_angles.sv -----
// top level: quaternion to euler angles for twelve rotation sequences
// depends on qte_pkg, qte_products, qte_isqrt, qte_cordic and the assertion header
//
//  channel   handshake              payload
//  input     start, busy            q_w, q_x, q_y, q_z
//  config    cfg_valid, cfg_ready   cfg_data (rot_seq)
//  result    done                   angle_first, angle_middle, angle_last, domain_clamped
//
// one quaternion per cycle
// pipeline: front end (4), bit-per-stage square root (32), cordic pipes (1 + steps), output (1)
// busy stays low: the pipeline never holds, results leave on the done strobe
// reset clears all valid bits and sets rot_seq to code 4 (yxz)
module quaternion_to_euler_angles #(
    parameter int QUAT_WIDTH   = qte_pkg::QUAT_WIDTH_DEF,
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [QUAT_WIDTH-1:0]       q_w,
    input  logic signed [QUAT_WIDTH-1:0]       q_x,
    input  logic signed [QUAT_WIDTH-1:0]       q_y,
    input  logic signed [QUAT_WIDTH-1:0]       q_z,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qte_pkg::SEQ_W-1:0]          cfg_data,
    output logic                               done,
    output logic signed [qte_pkg::OUT_W-1:0]   angle_first,
    output logic signed [qte_pkg::OUT_W-1:0]   angle_middle,
    output logic signed [qte_pkg::OUT_W-1:0]   angle_last,
    output logic                               domain_clamped
);
    import qte_pkg::*;

    `include "quaternion_to_euler_angles_assert.svh"

    localparam int CORD_LAT = CORDIC_STEPS + 1;
    localparam int LAT      = PROD_LAT + SQRT_LAT + CORD_LAT + 1;

    logic [SEQ_W-1:0] seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SEQ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seq_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic              fe_valid;
    logic [SQ_W-1:0]   fe_csq;
    qte_pay_t          fe_pay;

    qte_products #(.QUAT_WIDTH(QUAT_WIDTH)) u_products (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .q_w       (q_w),
        .q_x       (q_x),
        .q_y       (q_y),
        .q_z       (q_z),
        .seq       (seq_reg),
        .out_valid (fe_valid),
        .c_sq      (fe_csq),
        .pay       (fe_pay)
    );

    logic                     sq_valid;
    logic signed [PROD_W-1:0] sq_s;
    qte_pay_t                 sq_pay;

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .c_sq      (fe_csq),
        .in_pay    (fe_pay),
        .out_valid (sq_valid),
        .s         (sq_s),
        .out_pay   (sq_pay)
    );

    // operand routing: two-axis sequences swap the outer angles and use acos
    logic signed [CORD_W-1:0] y1, x1, y2, x2, y3, x3;
    logic signed [CORD_W-1:0] r11, r12, r31, r32, cc, ss;

    always_comb
    begin
        r11 = CORD_W'(sq_pay.r11);
        r12 = CORD_W'(sq_pay.r12);
        r31 = CORD_W'(sq_pay.r31);
        r32 = CORD_W'(sq_pay.r32);
        cc  = CORD_W'(sq_pay.c);
        ss  = CORD_W'(sq_s);
        if (sq_pay.odd)
        begin
            y1 = r11; x1 = r12;
            y2 = ss;  x2 = cc;
            y3 = r31; x3 = r32;
        end
        else
        begin
            y1 = r31; x1 = r32;
            y2 = cc;  x2 = ss;
            y3 = r11; x3 = r12;
        end
    end

    logic                    cv1, cv2, cv3;
    logic signed [ANG_W-1:0] a1, a2, a3;

    qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_first (
        .clk (clk), .rst_n (rst_n), .in_valid (sq_valid),
        .y (y1), .x (x1), .out_valid (cv1), .angle (a1)
    );

    qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_middle (
        .clk (clk), .rst_n (rst_n), .in_valid (sq_valid),
        .y (y2), .x (x2), .out_valid (cv2), .angle (a2)
    );

    qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_last (
        .clk (clk), .rst_n (rst_n), .in_valid (sq_valid),
        .y (y3), .x (x3), .out_valid (cv3), .angle (a3)
    );

    // flags ride alongside the cordic pipes
    logic flag_bad_reg [CORD_LAT];
    logic flag_clp_reg [CORD_LAT];

    always_ff @(posedge clk)
    begin
        flag_bad_reg[0] <= sq_pay.bad;
        flag_clp_reg[0] <= sq_pay.clamped;
        for (int i = 1; i < CORD_LAT; i++)
        begin
            flag_bad_reg[i] <= flag_bad_reg[i-1];
            flag_clp_reg[i] <= flag_clp_reg[i-1];
        end
    end

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] v;
        begin
            v = (a + ANG_W'(256)) >>> 9;
            if (v > ANG_W'(OUT_MAX))
            begin
                return OUT_MAX;
            end
            else if (v < -ANG_W'(OUT_MAX))
            begin
                return -OUT_MAX;
            end
            return v[OUT_W-1:0];
        end
    endfunction

    logic                    done_reg;
    logic signed [OUT_W-1:0] first_reg, middle_reg, last_reg;
    logic                    clamp_reg;
    logic                    bad;

    assign bad = flag_bad_reg[CORD_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cv1 && cv2 && cv3;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= bad ? '0 : to_out(a1);
        middle_reg <= bad ? '0 : to_out(a2);
        last_reg   <= bad ? '0 : to_out(a3);
        clamp_reg  <= bad ? 1'b0 : flag_clp_reg[CORD_LAT-1];
    end

    assign done           = done_reg;
    assign angle_first    = first_reg;
    assign angle_middle   = middle_reg;
    assign angle_last     = last_reg;
    assign domain_clamped = clamp_reg;

    `QTE_ASSERT_IMPLIES(a_done_follows_start, done, $past(start, LAT),
        "result strobe without a matching accepted quaternion")
    `QTE_ASSERT_IMPLIES(a_angle_range, done,
        (angle_first <= OUT_MAX) && (angle_first >= -OUT_MAX) &&
        (angle_middle <= OUT_MAX) && (angle_middle >= -OUT_MAX) &&
        (angle_last <= OUT_MAX) && (angle_last >= -OUT_MAX),
        "angle outside the saturation range")
    `QTE_ASSERT_ALWAYS(a_cordic_lockstep, (cv1 == cv2) && (cv2 == cv3),
        "cordic pipes out of step")

endmodule

// ----- tb/sv/quaternion_to_euler_angles_tb.sv -----
// self-checking testbench for quaternion_to_euler_angles: predicts the three angles and
// the clamp flag for each accepted quaternion and checks them in order
// depends on qte_pkg and the quaternion_to_euler_angles rtl
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;
    import qte_pkg::*;

    localparam int LATENCY    = 39 + CORDIC_STEPS_DEF;
    localparam int CYCLE_STOP = 400000;
    localparam int N_RANDOM   = 1500;

    typedef struct {
        logic signed [15:0] first;
        logic signed [15:0] middle;
        logic signed [15:0] last;
        logic               clamped;
    } angles_t;

    class angle_scoreboard;
        angles_t    pending[$];
        logic [3:0] seq;
        int         errors;
        int         checked;

        function new();
            seq = SEQ_RESET;
            errors = 0;
            checked = 0;
        endfunction

        // floor shift right of a signed value
        function automatic longint fshr(longint v, int s);
            return v >>> s;
        endfunction

        function automatic longint prod(longint a, longint b);
            return a * b * 1;
        endfunction

        function automatic longint int_sqrt(longint v);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > v) b = b >>> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        endfunction

        // vectoring cordic, degrees * 65536
        function automatic longint atan2_deg(longint y, longint x);
            longint z;
            longint xs;
            longint ys;
            z = 0;
            if (x < 0)
            begin
                z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF; i++)
            begin
                xs = fshr(x, i);
                ys = fshr(y, i);
                if (y >= 0)
                begin
                    x = x + ys; y = y - xs; z = z + longint'(atan_tab(5'(i)));
                end
                else
                begin
                    x = x - ys; y = y + xs; z = z - longint'(atan_tab(5'(i)));
                end
            end
            return z;
        endfunction

        function automatic logic signed [15:0] to_deg128(longint a);
            longint v;
            v = fshr(a + 256, 9);
            if (v > 23040) v = 23040;
            if (v < -23040) v = -23040;
            return 16'(v);
        endfunction

        function automatic longint pick(longint t[10], logic signed [4:0] code);
            if (code < 0)
                return -t[-code];
            return t[code];
        endfunction

        function automatic angles_t predict(logic signed [15:0] qw, logic signed [15:0] qx,
                                            logic signed [15:0] qy, logic signed [15:0] qz);
            angles_t    e;
            longint     w, x, y, z, ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, c, s, one;
            longint     t[10];
            longint     r[5];
            logic [24:0] row;
            w = qw; x = qx; y = qy; z = qz;
            one = 64'sd1 <<< 30;
            e.first = 0; e.middle = 0; e.last = 0; e.clamped = 0;
            if (seq >= NUM_SEQ)
                return e;
            ww = prod(w, w); xx = prod(x, x); yy = prod(y, y); zz = prod(z, z);
            xy = prod(x, y); xz = prod(x, z); yz = prod(y, z);
            wx = prod(w, x); wy = prod(w, y); wz = prod(w, z);
            t[0] = 0;
            t[1] = 2 * (xy + wz); t[2] = 2 * (xy - wz);
            t[3] = 2 * (xz + wy); t[4] = 2 * (xz - wy);
            t[5] = 2 * (yz + wx); t[6] = 2 * (yz - wx);
            t[7] = ww + xx - yy - zz;
            t[8] = ww - xx + yy - zz;
            t[9] = ww - xx - yy + zz;
            // row holds r11 in its low bits
            row = seq_row(seq);
            for (int k = 0; k < 5; k++)
                r[k] = pick(t, row[k*5 +: 5]);
            c = r[2];
            if (c > one)
            begin
                c = one; e.clamped = 1;
            end
            if (c < -one)
            begin
                c = -one; e.clamped = 1;
            end
            s = int_sqrt(one * one - c * c);
            if (!seq[0])
            begin
                e.first  = to_deg128(atan2_deg(r[3], r[4]));
                e.middle = to_deg128(atan2_deg(c, s));
                e.last   = to_deg128(atan2_deg(r[0], r[1]));
            end
            else
            begin
                e.first  = to_deg128(atan2_deg(r[0], r[1]));
                e.middle = to_deg128(atan2_deg(s, c));
                e.last   = to_deg128(atan2_deg(r[3], r[4]));
            end
            return e;
        endfunction

        function void note_input(logic signed [15:0] qw, logic signed [15:0] qx,
                                 logic signed [15:0] qy, logic signed [15:0] qz);
            pending.push_back(predict(qw, qx, qy, qz));
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d (seq %0d)", what, got, want, seq);
            errors++;
        endtask

        task check_result(angles_t got);
            angles_t e;
            if (pending.size() == 0)
            begin
                report("unexpected transaction", 1, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.first !== e.first) report("angle_first", got.first, e.first);
            if (got.middle !== e.middle) report("angle_middle", got.middle, e.middle);
            if (got.last !== e.last) report("angle_last", got.last, e.last);
            if (got.clamped !== e.clamped) report("domain_clamped", got.clamped, e.clamped);
        endtask
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [15:0] q_w = 0, q_x = 0, q_y = 0, q_z = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [3:0]         cfg_data = 0;
    logic               done;
    logic signed [15:0] angle_first, angle_middle, angle_last;
    logic               domain_clamped;

    angle_scoreboard sb = new();
    int              cycles = 0;
    int              sent = 0;

    quaternion_to_euler_angles u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .q_w(q_w), .q_x(q_x), .q_y(q_y), .q_z(q_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .angle_first(angle_first), .angle_middle(angle_middle),
        .angle_last(angle_last), .domain_clamped(domain_clamped)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        angles_t got;
        cycles++;
        if (cycles > CYCLE_STOP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (rst_n && done)
        begin
            got.first = angle_first;
            got.middle = angle_middle;
            got.last = angle_last;
            got.clamped = domain_clamped;
            sb.check_result(got);
        end
    end

    // one quaternion transaction, holding start across back-to-back items
    task send(logic signed [15:0] w, logic signed [15:0] x,
              logic signed [15:0] y, logic signed [15:0] z, int gap);
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        q_w <= w; q_x <= x; q_y <= y; q_z <= z;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_input(w, x, y, z);
        sent++;
    endtask

    task drain();
        start <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task write_seq(logic [3:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        sb.seq = v;
    endtask

    function automatic logic signed [15:0] rnd_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int rnd_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // roughly unit quaternion with random direction
    task send_unit(int gap);
        real a, b, c, d, n;
        a = real'($urandom_range(0, 2000)) - 1000.0;
        b = real'($urandom_range(0, 2000)) - 1000.0;
        c = real'($urandom_range(0, 2000)) - 1000.0;
        d = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
        send(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
             16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)), gap);
    endtask

    initial
    begin
        logic [3:0] seqs[5];
        seqs = '{4'd0, 4'd11, 4'd7, 4'd15, 4'd2};
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset sequence, extremes, zero vector, gimbal lock, non-unit
        send(16'sh7fff, 0, 0, 0, 0);
        send(0, 0, 0, 0, 0);
        send(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
        send(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
        send(16'sh5a82, 0, 16'sh5a82, 0, 0);
        send(16'sh5a82, 16'sh5a82, 0, 0, 0);
        send(16'sh5a82, 0, 0, 16'sh5a82, 0);
        send(0, 16'sh7fff, 0, 0, 2);
        send(0, 0, 0, 16'sh8000, 0);
        send(16'sh8000, 16'sh7fff, 0, 0, 0);
        send(-1, -1, -1, -1, 0);
        send(1, -1, 1, -1, 0);
        drain();

        // every sequence with a few fixed and unit quaternions
        for (int s = 0; s < 16; s++)
        begin
            write_seq(4'(s));
            send(16'sh4000, 16'sh2000, 16'shc000, 16'sh6000, 0);
            send(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
            send_unit(0);
            drain();
        end

        for (int p = 0; p < 5; p++)
        begin
            write_seq(seqs[p]);
            for (int i = 0; i < N_RANDOM / 5; i++)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_unit((i % 100 < 40) ? 0 : rnd_gap());
                else
                    send(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_gap());
                // hold off until the pipeline is empty
                if (i == 150)
                begin
                    start <= 0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        $display("sent %0d quaternions over all sixteen sequence codes, %0d results checked",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+design
design/qte_pkg.sv
design/qte_products.sv
design/qte_isqrt.sv
design/qte_cordic.sv
design/quaternion_to_euler_angles.sv
tb/sv/quaternion_to_euler_angles_tb.sv
